FILE: hdl/ddd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and calendar tables for the date difference block.
package ddd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DIST_W  = 22;
  localparam int unsigned STAT_W  = 2;
  // Day number of a date counted from 0000-01-01; covers year 16383.
  localparam int unsigned DNUM_W  = 23;
  localparam int unsigned YOFF_W  = 9;

  localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FIRST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_SECOND_BAD = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = 22'd4194303;

  // floor(x / 100) = (x * RECIP_100) >> 19 and floor(x / 400) = (x * RECIP_100) >> 21,
  // exact for x below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned SHIFT_100   = 19;
  localparam int unsigned SHIFT_400   = 21;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
  } dates_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DIST_W-1:0] day_distance;
  } result_t;

  // Length of a month; February follows the leap flag.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of the month.
  function automatic logic [YOFF_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [YOFF_W-1:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/ddd_date_pipe.sv
`timescale 1ns / 1ps
// Three-stage pipeline that checks one date and turns it into a day number.
module ddd_date_pipe #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                           clk,
  input  logic [2:0]                     en,
  input  logic [ddd_pkg::YEAR_W-1:0]     year,
  input  logic [ddd_pkg::MONTH_W-1:0]    month,
  input  logic [ddd_pkg::DAY_W-1:0]      day,
  output logic                           date_ok,
  output logic [ddd_pkg::DNUM_W-1:0]     day_num
);

  // stage 1: divisions by reciprocal, year times 365
  logic [27:0] prod_y;
  logic [27:0] prod_c100;
  logic [27:0] prod_c400;

  logic [ddd_pkg::YEAR_W-1:0]  s1_year;
  logic [ddd_pkg::MONTH_W-1:0] s1_month;
  logic [ddd_pkg::DAY_W-1:0]   s1_day;
  logic [7:0]                  s1_q100;
  logic [7:0]                  s1_c100;
  logic [5:0]                  s1_c400;
  logic [ddd_pkg::DNUM_W-1:0]  s1_y365;

  function automatic logic [ddd_pkg::DNUM_W-1:0] s1_y365_next(
      input logic [ddd_pkg::YEAR_W-1:0] y);
    return ddd_pkg::DNUM_W'(y) * ddd_pkg::DNUM_W'(365);
  endfunction

  assign prod_y    = 28'(year) * 28'(ddd_pkg::RECIP_100);
  assign prod_c100 = (28'(year) + 28'd99) * 28'(ddd_pkg::RECIP_100);
  assign prod_c400 = (28'(year) + 28'd399) * 28'(ddd_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_year  <= year;
      s1_month <= month;
      s1_day   <= day;
      s1_q100  <= 8'(prod_y >> ddd_pkg::SHIFT_100);
      s1_c100  <= 8'(prod_c100 >> ddd_pkg::SHIFT_100);
      s1_c400  <= 6'(prod_c400 >> ddd_pkg::SHIFT_400);
      s1_y365  <= ddd_pkg::DNUM_W'(s1_y365_next(year));
    end
  end

  // stage 2: leap rule, validity, year and month parts of the day number
  logic                        leap;
  logic                        cent;
  logic [ddd_pkg::DAY_W-1:0]   len;
  logic                        ok_next;
  logic [ddd_pkg::DNUM_W-1:0]  ypart_next;
  logic [ddd_pkg::YOFF_W-1:0]  mpart_next;

  logic                        s2_ok;
  logic [ddd_pkg::DNUM_W-1:0]  s2_ypart;
  logic [ddd_pkg::YOFF_W-1:0]  s2_mpart;

  always_comb begin
    cent = (s1_year == ddd_pkg::YEAR_W'(s1_q100) * ddd_pkg::YEAR_W'(100));
    // divisible by 4, and not a century unless the century count divides by 4
    leap = (s1_year[1:0] == 2'b00) && (!cent || (s1_q100[1:0] == 2'b00));
    len  = ddd_pkg::month_len(s1_month, leap);
    ok_next = (s1_year <= ddd_pkg::YEAR_W'(MAX_YEAR))
           && (s1_month >= ddd_pkg::MONTH_JAN) && (s1_month <= ddd_pkg::MONTH_DEC)
           && (s1_day != '0) && (s1_day <= len);
    ypart_next = s1_y365
               + ddd_pkg::DNUM_W'(s1_year[ddd_pkg::YEAR_W-1:2])
               + ddd_pkg::DNUM_W'(s1_year[1:0] != 2'b00)
               + ddd_pkg::DNUM_W'(s1_c400)
               - ddd_pkg::DNUM_W'(s1_c100);
    mpart_next = ddd_pkg::month_start(s1_month)
               + ddd_pkg::YOFF_W'((s1_month > ddd_pkg::MONTH_FEB) && leap)
               + ddd_pkg::YOFF_W'(s1_day)
               - ddd_pkg::YOFF_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_ok    <= ok_next;
      s2_ypart <= ypart_next;
      s2_mpart <= mpart_next;
    end
  end

  // stage 3: final day number
  always_ff @(posedge clk) begin
    if (en[2]) begin
      date_ok <= s2_ok;
      day_num <= s2_ypart + ddd_pkg::DNUM_W'(s2_mpart);
    end
  end

endmodule

FILE: hdl/ddd_dist.sv
`timescale 1ns / 1ps
// Two-stage difference, absolute value, saturation and status of a date pair.
module ddd_dist (
  input  logic                        clk,
  input  logic [1:0]                  en,
  input  logic                        ok_a,
  input  logic [ddd_pkg::DNUM_W-1:0]  day_a,
  input  logic                        ok_b,
  input  logic [ddd_pkg::DNUM_W-1:0]  day_b,
  output ddd_pkg::result_t            result
);

  logic [ddd_pkg::STAT_W-1:0]  s4_status;
  logic [ddd_pkg::DNUM_W:0]    s4_diff;
  logic [ddd_pkg::STAT_W-1:0]  status_next;

  always_comb begin
    if (!ok_a) begin
      status_next = ddd_pkg::STATUS_FIRST_BAD;
    end else if (!ok_b) begin
      status_next = ddd_pkg::STATUS_SECOND_BAD;
    end else begin
      status_next = ddd_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_status <= status_next;
      s4_diff   <= {1'b0, day_a} - {1'b0, day_b};
    end
  end

  logic [ddd_pkg::DNUM_W:0] mag;
  ddd_pkg::result_t         result_next;

  always_comb begin
    mag = s4_diff[ddd_pkg::DNUM_W] ? (~s4_diff + 1'b1) : s4_diff;
    result_next.status = s4_status;
    if (s4_status != ddd_pkg::STATUS_OK) begin
      result_next.day_distance = '0;
    end else if (mag > (ddd_pkg::DNUM_W+1)'(ddd_pkg::DIST_MAX)) begin
      result_next.day_distance = ddd_pkg::DIST_MAX;
    end else begin
      result_next.day_distance = mag[ddd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      result <= result_next;
    end
  end

endmodule

FILE: hdl/date_difference_in_days.sv
`timescale 1ns / 1ps
// Top level of the Gregorian date difference pipeline.
//
// Usage: present a pair of dates on dates with dates_valid; a transaction
// completes when dates_valid and dates_ready are both high. Each transaction
// yields exactly one result transaction on result/result_valid/result_ready:
// a status (ok, first date bad, second date bad) and the absolute number of
// days between the dates, zero when either date is bad.
// Between acceptance and result_valid, three stages turn each date into
// a day number (reciprocal multiplies, then the leap rule and partial
// sums, then the final add), one subtracts the two, and the output
// register holds the absolute value with saturation. Throughput is one
// date pair per cycle while the receiver takes results. Every stage has
// its own valid bit and loads whenever it is empty or the stage after it
// moves on, so a stalled receiver holds the result and backs the pipeline
// up stage by stage; empty stages still fill, and nothing is dropped or
// repeated. dates_ready follows result_ready combinationally through
// that chain. Reset (rst, synchronous) clears all valid bits; no result
// is shown until a new transaction has passed through.
module date_difference_in_days #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              dates_valid,
  output logic              dates_ready,
  input  ddd_pkg::dates_t   dates,
  output logic              result_valid,
  input  logic              result_ready,
  output ddd_pkg::result_t  result
);

  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] en;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[STAGES-1] = !stage_valid[STAGES-1] || result_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !stage_valid[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= dates_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign dates_ready  = en[0];
  assign result_valid = stage_valid[STAGES-1];

  logic                       ok_a;
  logic                       ok_b;
  logic [ddd_pkg::DNUM_W-1:0] day_a;
  logic [ddd_pkg::DNUM_W-1:0] day_b;

  ddd_date_pipe #(.MAX_YEAR(MAX_YEAR)) u_first (
    .clk     (clk),
    .en      (en[2:0]),
    .year    (dates.first_year),
    .month   (dates.first_month),
    .day     (dates.first_day),
    .date_ok (ok_a),
    .day_num (day_a)
  );

  ddd_date_pipe #(.MAX_YEAR(MAX_YEAR)) u_second (
    .clk     (clk),
    .en      (en[2:0]),
    .year    (dates.second_year),
    .month   (dates.second_month),
    .day     (dates.second_day),
    .date_ok (ok_b),
    .day_num (day_b)
  );

  ddd_dist u_dist (
    .clk    (clk),
    .en     (en[4:3]),
    .ok_a   (ok_a),
    .day_a  (day_a),
    .ok_b   (ok_b),
    .day_b  (day_b),
    .result (result)
  );

endmodule

FILE: hdl/ddd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the date difference block and its bind.
module ddd_checker (
  input logic              clk,
  input logic              rst,
  input logic              dates_ready,
  input logic              result_valid,
  input logic              result_ready,
  input ddd_pkg::result_t  result
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result shown right after reset");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ddd_pkg::STATUS_OK) |-> result.day_distance == '0)
    else $error("nonzero distance for an invalid date");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ddd_pkg::STATUS_OK)
                  || (result.status == ddd_pkg::STATUS_FIRST_BAD)
                  || (result.status == ddd_pkg::STATUS_SECOND_BAD))
    else $error("undefined status code");

  // an empty pipeline must take a new transaction
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> dates_ready)
    else $error("not ready after reset");

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (
  .clk          (clk),
  .rst          (rst),
  .dates_ready  (dates_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: test/date_distance_checker.sv
`timescale 1ns / 1ps
// Checker: predicts the day distance of each accepted date pair and compares results.
module date_distance_checker #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             dates_valid,
  input  logic             dates_ready,
  input  ddd_pkg::dates_t  dates,
  input  logic             result_valid,
  input  logic             result_ready,
  input  ddd_pkg::result_t result,
  output int               mismatches,
  output int               in_flight
);

  ddd_pkg::result_t expected_q[$];
  int               fail_total = 0;
  int               queued     = 0;

  assign mismatches = fail_total;
  assign in_flight  = queued;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_valid(input int unsigned y, input int unsigned m,
                                    input int unsigned d);
    if (y > MAX_YEAR || m < 1 || m > 12 || d < 1) return 1'b0;
    return d <= days_in_month(y, m);
  endfunction

  // Days since 0000-01-01, proleptic Gregorian.
  function automatic int unsigned day_index(input int unsigned y, input int unsigned m,
                                            input int unsigned d);
    int unsigned n;
    int unsigned k;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (k = 1; k < m; k++) n += days_in_month(y, k);
    return n + d - 1;
  endfunction

  function automatic ddd_pkg::result_t predict_distance(input ddd_pkg::dates_t p);
    ddd_pkg::result_t r;
    int unsigned      a;
    int unsigned      b;
    int unsigned      span;
    r.status       = ddd_pkg::STATUS_OK;
    r.day_distance = '0;
    if (!date_valid(32'(p.first_year), 32'(p.first_month), 32'(p.first_day))) begin
      r.status = ddd_pkg::STATUS_FIRST_BAD;
    end else if (!date_valid(32'(p.second_year), 32'(p.second_month),
                             32'(p.second_day))) begin
      r.status = ddd_pkg::STATUS_SECOND_BAD;
    end else begin
      a    = day_index(32'(p.first_year), 32'(p.first_month), 32'(p.first_day));
      b    = day_index(32'(p.second_year), 32'(p.second_month), 32'(p.second_day));
      span = (a > b) ? a - b : b - a;
      if (span > 32'(ddd_pkg::DIST_MAX)) span = 32'(ddd_pkg::DIST_MAX);
      r.day_distance = ddd_pkg::DIST_W'(span);
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    ddd_pkg::result_t want;
    if (rst) begin
      expected_q.delete();
    end else begin
      if (dates_valid && dates_ready) expected_q.push_back(predict_distance(dates));
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("status: no transaction pending, actual %0d", result.status);
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            fail_total++;
          end
          if (result.day_distance !== want.day_distance) begin
            $error("day_distance: expected %0d, actual %0d",
                   want.day_distance, result.day_distance);
            fail_total++;
          end
        end
      end
    end
    queued = expected_q.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the date difference testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;

  localparam int unsigned MAX_YEAR    = 9999;
  localparam int          NUM_RANDOM  = 550;
  localparam int          STALL_LIMIT = 5000;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             dates_valid  = 1'b0;
  logic             result_ready = 1'b0;
  ddd_pkg::dates_t  dates        = '0;
  logic             dates_ready;
  logic             result_valid;
  ddd_pkg::result_t result;
  int               mismatches;
  int               in_flight;
  bit               long_stall_req = 1'b0;
  int               idle_cycles    = 0;

  date_difference_in_days #(.MAX_YEAR(MAX_YEAR)) dut (
    .clk          (clk),
    .rst          (rst),
    .dates_valid  (dates_valid),
    .dates_ready  (dates_ready),
    .dates        (dates),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  date_distance_checker #(.MAX_YEAR(MAX_YEAR)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .dates_valid  (dates_valid),
    .dates_ready  (dates_ready),
    .dates        (dates),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .in_flight    (in_flight)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one date pair and hold it until the transaction completes.
  task automatic send_dates(input ddd_pkg::dates_t p);
    dates_valid <= 1'b1;
    dates       <= p;
    do @(posedge clk); while (!dates_ready);
  endtask

  task automatic send_pair(input int unsigned y1, input int unsigned m1, input int unsigned d1,
                           input int unsigned y2, input int unsigned m2, input int unsigned d2);
    ddd_pkg::dates_t p;
    p.first_year   = ddd_pkg::YEAR_W'(y1);
    p.first_month  = ddd_pkg::MONTH_W'(m1);
    p.first_day    = ddd_pkg::DAY_W'(d1);
    p.second_year  = ddd_pkg::YEAR_W'(y2);
    p.second_month = ddd_pkg::MONTH_W'(m2);
    p.second_day   = ddd_pkg::DAY_W'(d2);
    send_dates(p);
  endtask

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 99) * 100 + $urandom_range(0, 4);
      1:       return $urandom_range(0, 12);
      2:       return $urandom_range(9990, 9999);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  // Mostly in range; days past 28 may run off the end of the month.
  function automatic int unsigned pick_day();
    if ($urandom_range(0, 3) == 0) return $urandom_range(28, 31);
    return $urandom_range(1, 28);
  endfunction

  function automatic ddd_pkg::dates_t random_dates();
    ddd_pkg::dates_t p;
    logic [63:0]     raw;
    int unsigned     y1;
    int unsigned     y2;
    int unsigned     sel;
    sel = $urandom_range(0, 9);
    if (sel == 9) begin
      raw = {$urandom, $urandom};
      p   = raw[$bits(ddd_pkg::dates_t)-1:0];
      return p;
    end
    y1 = pick_year();
    if ($urandom_range(0, 1) == 1) begin
      y2 = pick_year();
    end else begin
      y2 = y1 + $urandom_range(0, 2);
      if (y2 > MAX_YEAR) y2 = MAX_YEAR;
    end
    p.first_year   = ddd_pkg::YEAR_W'(y1);
    p.first_month  = ddd_pkg::MONTH_W'($urandom_range(1, 12));
    p.first_day    = ddd_pkg::DAY_W'(pick_day());
    p.second_year  = ddd_pkg::YEAR_W'(y2);
    p.second_month = ddd_pkg::MONTH_W'($urandom_range(1, 12));
    p.second_day   = ddd_pkg::DAY_W'(pick_day());
    // Break one field of one date.
    if (sel >= 7) begin
      case ($urandom_range(0, 5))
        0: p.first_year   = ddd_pkg::YEAR_W'($urandom_range(MAX_YEAR + 1, 16383));
        1: p.first_month  = ($urandom_range(0, 1) == 0) ? '0
                          : ddd_pkg::MONTH_W'($urandom_range(13, 15));
        2: p.first_day    = '0;
        3: p.second_year  = ddd_pkg::YEAR_W'($urandom_range(MAX_YEAR + 1, 16383));
        4: p.second_month = ($urandom_range(0, 1) == 0) ? '0
                          : ddd_pkg::MONTH_W'($urandom_range(13, 15));
        default: p.second_day = '0;
      endcase
    end
    return p;
  endfunction

  // Receiver: changing stall patterns, plus one long hold-off on request.
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int cyc;
    bit hold_taken;
    logic nxt;
    mode_left  = 0;
    hold_left  = 0;
    cyc        = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (long_stall_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else begin
        case (mode)
          0:       nxt = 1'b1;
          1:       nxt = 1'($urandom_range(0, 1));
          2:       nxt = ($urandom_range(0, 3) == 0);
          default: nxt = (cyc % 3 != 0);
        endcase
      end
      result_ready <= nxt;
    end
  end

  // Abort when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (dates_valid && dates_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int burst_left;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_pair(2000, 1, 1, 2000, 1, 1);
    send_pair(0, 1, 1, 9999, 12, 31);
    send_pair(9999, 12, 31, 0, 1, 1);
    send_pair(9999, 12, 31, 9999, 12, 31);
    send_pair(1999, 12, 31, 2000, 1, 1);
    send_pair(2000, 2, 29, 2000, 3, 1);
    send_pair(0, 2, 29, 0, 3, 1);
    send_pair(2004, 2, 29, 1900, 2, 28);
    send_pair(2100, 3, 1, 2100, 2, 28);
    send_pair(1900, 2, 29, 2000, 1, 1);
    send_pair(2000, 1, 1, 2001, 2, 29);
    send_pair(2000, 0, 1, 2000, 1, 1);
    send_pair(2000, 13, 1, 2000, 1, 1);
    send_pair(2000, 1, 1, 2000, 15, 1);
    send_pair(2000, 1, 0, 2000, 1, 1);
    send_pair(2000, 4, 31, 2000, 1, 1);
    send_pair(2000, 1, 31, 2000, 12, 31);
    send_pair(10000, 1, 1, 2000, 1, 1);
    send_pair(2000, 1, 1, 16383, 1, 1);
    send_pair(16383, 15, 31, 16383, 15, 31);
    send_pair(2000, 6, 31, 2000, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(1600, 2, 29, 1700, 2, 28);
    send_pair(1, 1, 1, 400, 12, 31);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // Stall the receiver while offering back to back so the pipeline backs up.
      if (i == 200) begin
        long_stall_req = 1'b1;
        burst_left     = 60;
      end
      // Let the pipeline drain completely once.
      if (i == 400) begin
        dates_valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
      end
      if (burst_left == 0) begin
        dates_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 15);
      end
      burst_left--;
      send_dates(random_dates());
    end

    dates_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
